>>> rtl/hse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types and constants for the heap sort engine: payload structs,
// memory port selects and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int AW        = $clog2(MAX_ITEMS);
  localparam int CW        = $clog2(MAX_ITEMS + 1);
  localparam int DW        = 32;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 last;
  } hse_item_t;

  typedef struct packed {
    logic signed [DW-1:0] sorted_value;
    logic                 last_res;
    logic                 overflow;
  } hse_res_t;

  // read address select
  typedef enum logic [2:0] {
    RD_NODE,
    RD_LEFT,
    RD_RIGHT,
    RD_ROOT,
    RD_TAIL,
    RD_OUT
  } hse_rd_sel_t;

  // write select for the sort phases
  typedef enum logic [1:0] {
    WR_NONE,
    WR_CUR,
    WR_CHILD,
    WR_TMP
  } hse_wr_sel_t;

  typedef struct packed {
    logic        load;
    hse_rd_sel_t rd_sel;
    hse_wr_sel_t wr_sel;
    logic        cap_cur;
    logic        cap_l;
    logic        cap_r;
    logic        cap_tmp;
    logic        build_step;
    logic        ext_step;
    logic        node_root;
    logic        node_child;
    logic        out_clear;
    logic        out_load;
  } hse_cmd_t;

  typedef struct packed {
    logic in_last;
    logic bidx_zero;
    logic size_le1;
    logic has_l;
    logic has_r;
    logic child_gt;
    logic out_free;
    logic out_final;
  } hse_stat_t;

endpackage

>>> rtl/heap_sort_engine.sv
`timescale 1ns / 1ps
// Loading accepts one input transaction per cycle, with item_ready high only while loading.
// After the closing transaction the heap build and extraction run through one memory read
// port, with each sift-down level reading the children of the node; read-out then loads
// each result into the result register once that register is free.
// Synchronous reset clears the sequencer, counters and result valid; memory is not cleared.
// ----------------------------------------------------------------------------
// heap_sort_engine
// Batch heap sorter for signed 32-bit values, emitting each batch in
// ascending order with an overflow mark when the batch exceeded the store.
// ----------------------------------------------------------------------------
module heap_sort_engine
  import hse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  hse_item_t item,
  output logic      res_valid,
  input  logic      res_ready,
  output hse_res_t  res
);

  hse_cmd_t  cmd;
  hse_stat_t stat;

  hse_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  hse_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .item      (item),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  // loading never collides with a sort write
  a_load_no_sort_wr: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> cmd.wr_sel == WR_NONE)
    else $error("sort write while loading");

  // result register only reloads when free
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten");

  // a child only moves up when it exists and beats the held value
  a_child_move: assert property (@(posedge clk) disable iff (rst)
    cmd.node_child |-> stat.has_l && stat.child_gt)
    else $error("bad sift-down step");

endmodule

>>> rtl/hse_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_datapath
// Element memory, heap index registers, sift-down compare and the result
// register of the heap sort engine.
// ----------------------------------------------------------------------------
module hse_datapath
  import hse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  hse_cmd_t  cmd,
  output hse_stat_t stat,
  input  hse_item_t item,
  output hse_res_t  res,
  output logic      res_valid,
  input  logic      res_ready
);

  logic signed [DW-1:0] mem [MAX_ITEMS];

  logic [CW-1:0]        count;
  logic                 ovf;
  logic [CW-1:0]        bidx;
  logic [CW-1:0]        size;
  logic [AW-1:0]        node;
  logic [CW-1:0]        oidx;
  logic signed [DW-1:0] cur;
  logic signed [DW-1:0] lval;
  logic signed [DW-1:0] rval;
  logic signed [DW-1:0] tmp;
  logic signed [DW-1:0] mq;

  logic [AW+1:0]        lft;
  logic [AW+1:0]        rgt;
  logic                 has_r;
  logic                 sel_r;
  logic signed [DW-1:0] cval;
  logic [AW-1:0]        rd_addr;
  logic                 has_room;
  logic [CW-1:0]        count_next;

  assign lft      = {1'b0, node, 1'b1};
  assign rgt      = lft + (AW+2)'(1);
  assign has_room = count < CW'(MAX_ITEMS);
  assign count_next = has_room ? count + CW'(1) : count;

  assign has_r = rgt < (AW+2)'(size);
  assign sel_r = has_r && (rval > lval);
  assign cval  = sel_r ? rval : lval;

  always_comb begin
    stat.in_last   = item.last;
    stat.bidx_zero = bidx == '0;
    stat.size_le1  = size <= CW'(1);
    stat.has_l     = lft < (AW+2)'(size);
    stat.has_r     = has_r;
    stat.child_gt  = cval > cur;
    stat.out_free  = !res_valid || res_ready;
    stat.out_final = (oidx + CW'(1)) == count;
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_NODE:  rd_addr = node;
      RD_LEFT:  rd_addr = lft[AW-1:0];
      RD_RIGHT: rd_addr = rgt[AW-1:0];
      RD_ROOT:  rd_addr = '0;
      RD_TAIL:  rd_addr = size[AW-1:0];
      RD_OUT:   rd_addr = oidx[AW-1:0];
      default:  rd_addr = node;
    endcase
  end

  // element memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (has_room) begin
        mem[count[AW-1:0]] <= item.value;
      end
    end else begin
      case (cmd.wr_sel)
        WR_CUR:   mem[node]         <= cur;
        WR_CHILD: mem[node]         <= cval;
        WR_TMP:   mem[size[AW-1:0]] <= tmp;
        default: ;
      endcase
    end
    mq <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_cur) cur  <= mq;
    if (cmd.cap_l)   lval <= mq;
    if (cmd.cap_r)   rval <= mq;
    if (cmd.cap_tmp) tmp  <= mq;
    if (cmd.out_load) begin
      res.sorted_value <= mq;
      res.last_res     <= stat.out_final;
      res.overflow     <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      bidx      <= '0;
      size      <= '0;
      node      <= '0;
      oidx      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        count <= count_next;
        if (!has_room) ovf <= 1'b1;
        if (item.last) begin
          size <= count_next;
          bidx <= count_next >> 1;
        end
      end
      if (cmd.build_step) begin
        bidx <= bidx - CW'(1);
        node <= AW'(bidx - CW'(1));
      end
      if (cmd.ext_step)   size <= size - CW'(1);
      if (cmd.node_root)  node <= '0;
      if (cmd.node_child) node <= sel_r ? rgt[AW-1:0] : lft[AW-1:0];
      if (cmd.out_clear)  oidx <= '0;
      if (cmd.out_load) begin
        oidx <= oidx + CW'(1);
        // batch closes with its final transaction
        if (stat.out_final) begin
          count <= '0;
          ovf   <= 1'b0;
        end
      end
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/hse_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_ctrl
// Sequencer for the heap sort engine: load, heap build, root extraction,
// hole-based sift-down and ordered read-out.
// ----------------------------------------------------------------------------
module hse_ctrl
  import hse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  hse_stat_t stat,
  output hse_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_BUILD_NEXT,
    S_SIFT_RDN,
    S_SIFT_CUR,
    S_SIFT_CHK,
    S_SIFT_L,
    S_SIFT_R,
    S_SIFT_CMP,
    S_EXT_NEXT,
    S_EXT_TAIL,
    S_EXT_SWAP,
    S_OUT_RD,
    S_OUT_CAP
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_ext;
  logic   in_ext_next;
  state_t ret;

  assign ret        = in_ext ? S_EXT_NEXT : S_BUILD_NEXT;
  assign item_ready = state == S_LOAD;

  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = RD_NODE;
    cmd.wr_sel  = WR_NONE;
    state_next  = state;
    in_ext_next = in_ext;
    case (state)
      S_LOAD: begin
        if (item_valid) begin
          cmd.load = 1'b1;
          if (stat.in_last) begin
            in_ext_next = 1'b0;
            state_next  = S_BUILD_NEXT;
          end
        end
      end
      S_BUILD_NEXT: begin
        if (stat.bidx_zero) begin
          state_next = S_EXT_NEXT;
        end else begin
          cmd.build_step = 1'b1;
          state_next     = S_SIFT_RDN;
        end
      end
      S_SIFT_RDN: begin
        cmd.rd_sel = RD_NODE;
        state_next = S_SIFT_CUR;
      end
      S_SIFT_CUR: begin
        cmd.cap_cur = 1'b1;
        state_next  = S_SIFT_CHK;
      end
      S_SIFT_CHK: begin
        if (!stat.has_l) begin
          cmd.wr_sel = WR_CUR;
          state_next = ret;
        end else begin
          cmd.rd_sel = RD_LEFT;
          state_next = S_SIFT_L;
        end
      end
      S_SIFT_L: begin
        cmd.cap_l = 1'b1;
        if (stat.has_r) begin
          cmd.rd_sel = RD_RIGHT;
          state_next = S_SIFT_R;
        end else begin
          state_next = S_SIFT_CMP;
        end
      end
      S_SIFT_R: begin
        cmd.cap_r  = 1'b1;
        state_next = S_SIFT_CMP;
      end
      S_SIFT_CMP: begin
        // larger child moves up into the hole, otherwise the held value lands
        if (stat.child_gt) begin
          cmd.wr_sel     = WR_CHILD;
          cmd.node_child = 1'b1;
          state_next     = S_SIFT_CHK;
        end else begin
          cmd.wr_sel = WR_CUR;
          state_next = ret;
        end
      end
      S_EXT_NEXT: begin
        in_ext_next = 1'b1;
        if (stat.size_le1) begin
          cmd.out_clear = 1'b1;
          state_next    = S_OUT_RD;
        end else begin
          cmd.rd_sel   = RD_ROOT;
          cmd.ext_step = 1'b1;
          state_next   = S_EXT_TAIL;
        end
      end
      S_EXT_TAIL: begin
        cmd.cap_tmp = 1'b1;
        cmd.rd_sel  = RD_TAIL;
        state_next  = S_EXT_SWAP;
      end
      S_EXT_SWAP: begin
        cmd.cap_cur   = 1'b1;
        cmd.wr_sel    = WR_TMP;
        cmd.node_root = 1'b1;
        state_next    = S_SIFT_CHK;
      end
      S_OUT_RD: begin
        cmd.rd_sel = RD_OUT;
        state_next = S_OUT_CAP;
      end
      S_OUT_CAP: begin
        cmd.rd_sel = RD_OUT;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = stat.out_final ? S_LOAD : S_OUT_RD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      in_ext <= 1'b0;
    end else begin
      state  <= state_next;
      in_ext <= in_ext_next;
    end
  end

endmodule
